// ----- src/sfps_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and the control-store program of the sprite fade/play sequencer.
package sfps_pkg;

  localparam int MAX_FRAMES    = 256;
  localparam int TIME_BITS_DEF = 32;

  localparam int FC_W    = 9;
  localparam int SPD_W   = 16;
  localparam int DLY_W   = 24;
  localparam int DELTA_W = 16;
  localparam int PHASE_W = 3;
  localparam int ALPHA_W = 8;
  localparam int FRAME_W = 8;

  localparam int SPD_SHIFT = 18;
  localparam int LEN_W     = FC_W + SPD_SHIFT;
  localparam int QUO_W     = LEN_W;
  localparam int DCNT_W    = $clog2(QUO_W + 1);
  localparam int ANUM_W    = DLY_W + ALPHA_W;
  localparam int MUL_W     = LEN_W + SPD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POST_DELAY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_TIME = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RETAIN_AT_END = 3'd7;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [PHASE_W-1:0] PH_PRE_DELAY  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FADE_IN    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PLAY       = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POST_DELAY = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FADE_OUT   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_ENDED      = 3'd5;

  localparam int UOP_W = 5;
  localparam logic [UOP_W-1:0] UOP_NOP      = 5'd0;
  localparam logic [UOP_W-1:0] UOP_IDLE     = 5'd1;
  localparam logic [UOP_W-1:0] UOP_DIV_LEN  = 5'd2;
  localparam logic [UOP_W-1:0] UOP_SET_B2   = 5'd3;
  localparam logic [UOP_W-1:0] UOP_SET_B3   = 5'd4;
  localparam logic [UOP_W-1:0] UOP_SET_B4   = 5'd5;
  localparam logic [UOP_W-1:0] UOP_SET_B5   = 5'd6;
  localparam logic [UOP_W-1:0] UOP_END      = 5'd7;
  localparam logic [UOP_W-1:0] UOP_ADD      = 5'd8;
  localparam logic [UOP_W-1:0] UOP_WRAP     = 5'd9;
  localparam logic [UOP_W-1:0] UOP_RES_END  = 5'd10;
  localparam logic [UOP_W-1:0] UOP_RES_PRE  = 5'd11;
  localparam logic [UOP_W-1:0] UOP_DIV_FIN  = 5'd12;
  localparam logic [UOP_W-1:0] UOP_RES_FIN  = 5'd13;
  localparam logic [UOP_W-1:0] UOP_MUL      = 5'd14;
  localparam logic [UOP_W-1:0] UOP_RES_PLAY = 5'd15;
  localparam logic [UOP_W-1:0] UOP_RES_POST = 5'd16;
  localparam logic [UOP_W-1:0] UOP_DIV_FOUT = 5'd17;
  localparam logic [UOP_W-1:0] UOP_RES_FOUT = 5'd18;
  localparam logic [UOP_W-1:0] UOP_EMIT     = 5'd19;
  localparam logic [UOP_W-1:0] UOP_RESTART  = 5'd20;

  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] COND_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] COND_NO_ITEM  = 4'd2;
  localparam logic [COND_W-1:0] COND_CLEAN    = 4'd3;
  localparam logic [COND_W-1:0] COND_DIV_RUN  = 4'd4;
  localparam logic [COND_W-1:0] COND_RESTART  = 4'd5;
  localparam logic [COND_W-1:0] COND_LT_B1    = 4'd6;
  localparam logic [COND_W-1:0] COND_LT_B2    = 4'd7;
  localparam logic [COND_W-1:0] COND_LT_B3    = 4'd8;
  localparam logic [COND_W-1:0] COND_LT_B4    = 4'd9;
  localparam logic [COND_W-1:0] COND_LT_B5    = 4'd10;
  localparam logic [COND_W-1:0] COND_OUT_FREE = 4'd11;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] ST_GEOM      = 5'd1;
  localparam logic [PC_W-1:0] ST_DIV_LEN   = 5'd2;
  localparam logic [PC_W-1:0] ST_B2        = 5'd3;
  localparam logic [PC_W-1:0] ST_B3        = 5'd4;
  localparam logic [PC_W-1:0] ST_B4        = 5'd5;
  localparam logic [PC_W-1:0] ST_B5        = 5'd6;
  localparam logic [PC_W-1:0] ST_END       = 5'd7;
  localparam logic [PC_W-1:0] ST_ADD       = 5'd8;
  localparam logic [PC_W-1:0] ST_WRAP      = 5'd9;
  localparam logic [PC_W-1:0] ST_CL1       = 5'd10;
  localparam logic [PC_W-1:0] ST_CL2       = 5'd11;
  localparam logic [PC_W-1:0] ST_CL3       = 5'd12;
  localparam logic [PC_W-1:0] ST_CL4       = 5'd13;
  localparam logic [PC_W-1:0] ST_CL5       = 5'd14;
  localparam logic [PC_W-1:0] ST_R_END     = 5'd15;
  localparam logic [PC_W-1:0] ST_R_PRE     = 5'd16;
  localparam logic [PC_W-1:0] ST_DIV_FIN   = 5'd17;
  localparam logic [PC_W-1:0] ST_WAIT_FIN  = 5'd18;
  localparam logic [PC_W-1:0] ST_R_FIN     = 5'd19;
  localparam logic [PC_W-1:0] ST_MUL       = 5'd20;
  localparam logic [PC_W-1:0] ST_R_PLAY    = 5'd21;
  localparam logic [PC_W-1:0] ST_R_POST    = 5'd22;
  localparam logic [PC_W-1:0] ST_DIV_FOUT  = 5'd23;
  localparam logic [PC_W-1:0] ST_WAIT_FOUT = 5'd24;
  localparam logic [PC_W-1:0] ST_R_FOUT    = 5'd25;
  localparam logic [PC_W-1:0] ST_EMIT      = 5'd26;
  localparam logic [PC_W-1:0] ST_HOLD      = 5'd27;
  localparam logic [PC_W-1:0] ST_RESTART   = 5'd28;

  typedef struct packed {
    logic [UOP_W-1:0]  uop;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: ST_IDLE};
    case (pc)
      ST_IDLE:      w = '{uop: UOP_IDLE,     cond: COND_NO_ITEM,  target: ST_IDLE};
      ST_GEOM:      w = '{uop: UOP_NOP,      cond: COND_CLEAN,    target: ST_END};
      ST_DIV_LEN:   w = '{uop: UOP_DIV_LEN,  cond: COND_NEVER,    target: ST_IDLE};
      ST_B2:        w = '{uop: UOP_SET_B2,   cond: COND_DIV_RUN,  target: ST_B2};
      ST_B3:        w = '{uop: UOP_SET_B3,   cond: COND_NEVER,    target: ST_IDLE};
      ST_B4:        w = '{uop: UOP_SET_B4,   cond: COND_NEVER,    target: ST_IDLE};
      ST_B5:        w = '{uop: UOP_SET_B5,   cond: COND_NEVER,    target: ST_IDLE};
      ST_END:       w = '{uop: UOP_END,      cond: COND_RESTART,  target: ST_RESTART};
      ST_ADD:       w = '{uop: UOP_ADD,      cond: COND_NEVER,    target: ST_IDLE};
      ST_WRAP:      w = '{uop: UOP_WRAP,     cond: COND_NEVER,    target: ST_IDLE};
      ST_CL1:       w = '{uop: UOP_NOP,      cond: COND_LT_B1,    target: ST_R_PRE};
      ST_CL2:       w = '{uop: UOP_NOP,      cond: COND_LT_B2,    target: ST_DIV_FIN};
      ST_CL3:       w = '{uop: UOP_NOP,      cond: COND_LT_B3,    target: ST_MUL};
      ST_CL4:       w = '{uop: UOP_NOP,      cond: COND_LT_B4,    target: ST_R_POST};
      ST_CL5:       w = '{uop: UOP_NOP,      cond: COND_LT_B5,    target: ST_DIV_FOUT};
      ST_R_END:     w = '{uop: UOP_RES_END,  cond: COND_ALWAYS,   target: ST_EMIT};
      ST_R_PRE:     w = '{uop: UOP_RES_PRE,  cond: COND_ALWAYS,   target: ST_EMIT};
      ST_DIV_FIN:   w = '{uop: UOP_DIV_FIN,  cond: COND_NEVER,    target: ST_IDLE};
      ST_WAIT_FIN:  w = '{uop: UOP_NOP,      cond: COND_DIV_RUN,  target: ST_WAIT_FIN};
      ST_R_FIN:     w = '{uop: UOP_RES_FIN,  cond: COND_ALWAYS,   target: ST_EMIT};
      ST_MUL:       w = '{uop: UOP_MUL,      cond: COND_NEVER,    target: ST_IDLE};
      ST_R_PLAY:    w = '{uop: UOP_RES_PLAY, cond: COND_ALWAYS,   target: ST_EMIT};
      ST_R_POST:    w = '{uop: UOP_RES_POST, cond: COND_ALWAYS,   target: ST_EMIT};
      ST_DIV_FOUT:  w = '{uop: UOP_DIV_FOUT, cond: COND_NEVER,    target: ST_IDLE};
      ST_WAIT_FOUT: w = '{uop: UOP_NOP,      cond: COND_DIV_RUN,  target: ST_WAIT_FOUT};
      ST_R_FOUT:    w = '{uop: UOP_RES_FOUT, cond: COND_NEVER,    target: ST_IDLE};
      ST_EMIT:      w = '{uop: UOP_EMIT,     cond: COND_OUT_FREE, target: ST_IDLE};
      ST_HOLD:      w = '{uop: UOP_NOP,      cond: COND_ALWAYS,   target: ST_EMIT};
      ST_RESTART:   w = '{uop: UOP_RESTART,  cond: COND_ALWAYS,   target: ST_IDLE};
      default:      w = '{uop: UOP_NOP,      cond: COND_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/sprite_fade_play_sequencer_top.sv -----
`timescale 1ns / 1ps
// Sprite fade/play sequencer: microcoded timeline stepper with shared divider and multiplier.
//
//   channel | ports                                                 | handshake
//   --------+-------------------------------------------------------+-----------------
//   input   | in_op, in_delta_time                                  | in_valid/in_ready
//   result  | out_phase, out_alpha, out_frame_index, out_frame_valid | out_valid/out_ready
//   config  | cfg_index, cfg_wdata                                  | cfg_we, no wait
//
// A tick's path from accept to result is set by the control program: the fade phases run
// the shared 1-bit-per-cycle divider for 8 steps. A restart clears the elapsed time.
// The first item after a write to frame_count, play_speed or a time register also runs
// the 27-step play length divide. Reset is synchronous, no clearing pass.
// A held result stalls the program in its emit step; in_ready is high only in the idle step.
module sprite_fade_play_sequencer_top
  import sfps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [DELTA_W-1:0]    in_delta_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PHASE_W-1:0]    out_phase,
  output logic [ALPHA_W-1:0]    out_alpha,
  output logic [FRAME_W-1:0]    out_frame_index,
  output logic                  out_frame_valid,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CMP_W = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W;

  logic [FC_W-1:0]      frame_count_r;
  logic [SPD_W-1:0]     play_speed_r;
  logic [DLY_W-1:0]     pre_delay_r;
  logic [DLY_W-1:0]     fade_in_time_r;
  logic [DLY_W-1:0]     post_delay_r;
  logic [DLY_W-1:0]     fade_out_time_r;
  logic                 loop_enable_r;
  logic                 retain_at_end_r;
  logic                 dirty_r;
  logic                 end_pend_r;

  logic [PC_W-1:0]      pc_r;
  logic [PC_W-1:0]      pc_nxt;
  logic                 op_r;
  logic [DELTA_W-1:0]   delta_r;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [LEN_W-1:0]     b2_r;
  logic [LEN_W-1:0]     b3_r;
  logic [LEN_W-1:0]     b4_r;
  logic [LEN_W-1:0]     b5_r;

  logic [DLY_W-1:0]     div_rem_r;
  logic [QUO_W-1:0]     div_quo_r;
  logic [DLY_W-1:0]     div_den_r;
  logic [DCNT_W-1:0]    div_cnt_r;
  logic [MUL_W-1:0]     mul_r;

  logic [PHASE_W-1:0]   res_phase_r;
  logic [ALPHA_W-1:0]   res_alpha_r;
  logic [FRAME_W-1:0]   res_frame_r;
  logic                 res_valid_r;
  logic                 out_valid_r;
  logic [PHASE_W-1:0]   out_phase_r;
  logic [ALPHA_W-1:0]   out_alpha_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic                 out_fvalid_r;

  uword_t               uw;
  logic                 in_accept;
  logic                 div_run;
  logic                 out_free;
  logic                 cond_true;
  logic [FC_W-1:0]      eff_frames;
  logic [SPD_W-1:0]     eff_speed;
  logic [FRAME_W-1:0]   last_frame;
  logic [CMP_W-1:0]     e_ext;
  logic [CMP_W-1:0]     b1_ext;
  logic [CMP_W-1:0]     b5_ext;
  logic [CMP_W-1:0]     tmax_ext;
  logic [CMP_W-1:0]     bnd_sel;
  logic                 e_lt;
  logic [TIME_BITS:0]   e_sum;
  logic [CMP_W-1:0]     fin_diff;
  logic [CMP_W-1:0]     fout_diff;
  logic [CMP_W-1:0]     play_diff;
  logic [ANUM_W-1:0]    a_num;
  logic [DLY_W:0]       div_trial;
  logic [DLY_W:0]       div_sub;
  logic                 div_ge;
  logic [MUL_W-SPD_SHIFT-1:0] frame_raw;

  assign uw         = ucode(pc_r);
  assign in_ready   = (uw.uop == UOP_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign div_run    = (div_cnt_r != '0);
  assign out_free   = !out_valid_r || out_ready;

  assign eff_frames = (frame_count_r == '0) ? FC_W'(1) :
                      (frame_count_r > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : frame_count_r;
  assign eff_speed  = (play_speed_r == '0) ? SPD_W'(1) : play_speed_r;
  assign last_frame = FRAME_W'(eff_frames - FC_W'(1));

  assign e_ext      = CMP_W'(elapsed_r);
  assign b1_ext     = CMP_W'(pre_delay_r);
  assign b5_ext     = CMP_W'(b5_r);
  assign tmax_ext   = CMP_W'({TIME_BITS{1'b1}});
  assign e_sum      = {1'b0, elapsed_r} + (TIME_BITS + 1)'(delta_r);
  assign fin_diff   = e_ext - b1_ext;
  assign fout_diff  = b5_ext - e_ext;
  assign play_diff  = e_ext - CMP_W'(b2_r);
  assign frame_raw  = mul_r[MUL_W-1:SPD_SHIFT];

  always_comb begin
    case (uw.cond)
      COND_LT_B1: bnd_sel = b1_ext;
      COND_LT_B2: bnd_sel = CMP_W'(b2_r);
      COND_LT_B3: bnd_sel = CMP_W'(b3_r);
      COND_LT_B4: bnd_sel = CMP_W'(b4_r);
      default:    bnd_sel = b5_ext;
    endcase
  end

  assign e_lt = (e_ext < bnd_sel);

  always_comb begin
    case (uw.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NO_ITEM:  cond_true = !in_accept;
      COND_CLEAN:    cond_true = !dirty_r;
      COND_DIV_RUN:  cond_true = div_run;
      COND_RESTART:  cond_true = (op_r == OP_RESTART);
      COND_LT_B1,
      COND_LT_B2,
      COND_LT_B3,
      COND_LT_B4,
      COND_LT_B5:    cond_true = e_lt;
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b0;
    endcase
  end

  assign pc_nxt = cond_true ? uw.target : pc_r + PC_W'(1);

  always_comb begin
    if (uw.uop == UOP_DIV_FOUT) begin
      a_num = {fout_diff[DLY_W-1:0], {ALPHA_W{1'b0}}} - ANUM_W'(fout_diff[DLY_W-1:0]);
    end else begin
      a_num = {fin_diff[DLY_W-1:0], {ALPHA_W{1'b0}}} - ANUM_W'(fin_diff[DLY_W-1:0]);
    end
  end

  assign div_trial = {div_rem_r, div_quo_r[QUO_W-1]};
  assign div_sub   = div_trial - {1'b0, div_den_r};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_op;
      delta_r <= in_delta_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (uw.uop == UOP_DIV_LEN || uw.uop == UOP_DIV_FIN || uw.uop == UOP_DIV_FOUT) begin
      div_cnt_r <= (uw.uop == UOP_DIV_LEN) ? DCNT_W'(QUO_W) : DCNT_W'(ALPHA_W);
    end else if (div_run) begin
      div_cnt_r <= div_cnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (uw.uop)
      UOP_DIV_LEN: begin
        div_rem_r <= '0;
        div_quo_r <= {eff_frames, {SPD_SHIFT{1'b0}}};
        div_den_r <= DLY_W'(eff_speed);
      end
      UOP_DIV_FIN, UOP_DIV_FOUT: begin
        div_rem_r <= a_num[ANUM_W-1:ALPHA_W];
        div_quo_r <= {a_num[ALPHA_W-1:0], {(QUO_W - ALPHA_W){1'b0}}};
        div_den_r <= (uw.uop == UOP_DIV_FIN) ? fade_in_time_r : fade_out_time_r;
      end
      default: begin
        if (div_run) begin
          div_rem_r <= div_ge ? div_sub[DLY_W-1:0] : div_trial[DLY_W-1:0];
          div_quo_r <= {div_quo_r[QUO_W-2:0], div_ge};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (uw.uop)
      UOP_SET_B2: b2_r <= LEN_W'(pre_delay_r) + LEN_W'(fade_in_time_r);
      UOP_SET_B3: b3_r <= b2_r + div_quo_r;
      UOP_SET_B4: b4_r <= b3_r + LEN_W'(post_delay_r);
      UOP_SET_B5: b5_r <= b4_r + LEN_W'(fade_out_time_r);
      UOP_MUL:    mul_r <= play_diff[LEN_W-1:0] * eff_speed;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (uw.uop)
      UOP_END: begin
        if (end_pend_r) begin
          elapsed_r <= (b5_ext > tmax_ext) ? {TIME_BITS{1'b1}} : b5_ext[TIME_BITS-1:0];
        end
      end
      UOP_ADD: begin
        elapsed_r <= e_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : e_sum[TIME_BITS-1:0];
      end
      UOP_WRAP: begin
        if (loop_enable_r && (e_ext > b5_ext)) begin
          elapsed_r <= TIME_BITS'(e_ext - b5_ext);
        end
      end
      UOP_RESTART: elapsed_r <= '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (uw.uop)
      UOP_RES_PRE: begin
        res_phase_r <= PH_PRE_DELAY;
        res_alpha_r <= '0;
        res_frame_r <= '0;
        res_valid_r <= 1'b1;
      end
      UOP_RES_FIN: begin
        res_phase_r <= PH_FADE_IN;
        res_alpha_r <= div_quo_r[ALPHA_W-1:0];
        res_frame_r <= '0;
        res_valid_r <= 1'b1;
      end
      UOP_RES_PLAY: begin
        res_phase_r <= PH_PLAY;
        res_alpha_r <= '1;
        res_frame_r <= (frame_raw > (MUL_W - SPD_SHIFT)'(last_frame)) ?
                       last_frame : frame_raw[FRAME_W-1:0];
        res_valid_r <= 1'b1;
      end
      UOP_RES_POST: begin
        res_phase_r <= PH_POST_DELAY;
        res_alpha_r <= '1;
        res_frame_r <= last_frame;
        res_valid_r <= 1'b1;
      end
      UOP_RES_FOUT: begin
        res_phase_r <= PH_FADE_OUT;
        res_alpha_r <= div_quo_r[ALPHA_W-1:0];
        res_frame_r <= last_frame;
        res_valid_r <= 1'b1;
      end
      UOP_RES_END: begin
        res_phase_r <= PH_ENDED;
        res_alpha_r <= retain_at_end_r ? '1 : '0;
        res_frame_r <= retain_at_end_r ? last_frame : '0;
        res_valid_r <= retain_at_end_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.uop == UOP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.uop == UOP_EMIT && out_free) begin
      out_phase_r  <= res_phase_r;
      out_alpha_r  <= res_alpha_r;
      out_frame_r  <= res_frame_r;
      out_fvalid_r <= res_valid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase       = out_phase_r;
  assign out_alpha       = out_alpha_r;
  assign out_frame_index = out_frame_r;
  assign out_frame_valid = out_fvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= FC_W'(1);
      play_speed_r    <= SPD_W'(256);
      pre_delay_r     <= '0;
      fade_in_time_r  <= '0;
      post_delay_r    <= '0;
      fade_out_time_r <= '0;
      loop_enable_r   <= 1'b0;
      retain_at_end_r <= 1'b1;
      dirty_r         <= 1'b1;
      end_pend_r      <= 1'b1;
    end else begin
      if (uw.uop == UOP_SET_B5) begin
        dirty_r <= 1'b0;
      end
      if (uw.uop == UOP_END) begin
        end_pend_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_COUNT: begin
            frame_count_r <= cfg_wdata[FC_W-1:0];
            dirty_r       <= 1'b1;
            end_pend_r    <= 1'b1;
          end
          REG_PLAY_SPEED: begin
            play_speed_r <= cfg_wdata[SPD_W-1:0];
            dirty_r      <= 1'b1;
          end
          REG_PRE_DELAY: begin
            pre_delay_r <= cfg_wdata[DLY_W-1:0];
            dirty_r     <= 1'b1;
            end_pend_r  <= 1'b1;
          end
          REG_FADE_IN_TIME: begin
            fade_in_time_r <= cfg_wdata[DLY_W-1:0];
            dirty_r        <= 1'b1;
            end_pend_r     <= 1'b1;
          end
          REG_POST_DELAY: begin
            post_delay_r <= cfg_wdata[DLY_W-1:0];
            dirty_r      <= 1'b1;
            end_pend_r   <= 1'b1;
          end
          REG_FADE_OUT_TIME: begin
            fade_out_time_r <= cfg_wdata[DLY_W-1:0];
            dirty_r         <= 1'b1;
            end_pend_r      <= 1'b1;
          end
          REG_LOOP_ENABLE: loop_enable_r <= cfg_wdata[0];
          REG_RETAIN_AT_END: begin
            retain_at_end_r <= cfg_wdata[0];
            end_pend_r      <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> div_cnt_r == '0)
    else $error("divider busy while idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> pc_r == ST_GEOM)
    else $error("accepted item did not start the program");

  a_classify_clean: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == ST_CL1 |-> !dirty_r && !end_pend_r)
    else $error("classify with stale boundaries");

  a_hidden_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fvalid_r |->
      out_phase_r == PH_ENDED && out_alpha_r == '0 && out_frame_r == '0)
    else $error("hidden result carries a frame");

  a_fade_in_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_phase_r == PH_FADE_IN |-> out_alpha_r != '1)
    else $error("fade-in alpha reached full");

endmodule
